### rtl/flc_pkg.sv
`timescale 1ns / 1ps
// flc_pkg: shared types and constants of the free list object cache.
// No dependencies.
package flc_pkg;

  localparam int HANDLE_W = 12;
  localparam int HEAD_W   = 13;
  localparam int BYTES_W  = 21;
  localparam int SIZE_W   = 15;
  localparam int CPU_W    = 2;
  localparam int BIN_W    = 4;
  localparam int ENTRY_W  = HEAD_W + BYTES_W;

  localparam logic [BYTES_W-1:0] BYTES_MAX   = 21'h1F_FFFF;
  localparam logic [BYTES_W-1:0] LIMIT_RESET = 21'h10_0000;

  localparam logic MODE_GET = 1'b0;
  localparam logic MODE_PUT = 1'b1;

  localparam int              CFG_ADDR_W     = 3;
  localparam logic [2:0]      ADDR_BYTE_LIMIT = 3'd0;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOK,
    S_POP
  } state_t;

  typedef struct packed {
    logic clear;
    logic capture;
    logic look;
    logic pop;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic need_pop;
    logic out_free;
  } sts_t;

endpackage

### rtl/flc_in_if.sv
`timescale 1ns / 1ps
// flc_in_if: request channel (valid/ready plus get/put fields).
// Depends on flc_pkg.
interface flc_in_if;
  logic                          valid;
  logic                          ready;
  logic                          mode;
  logic [flc_pkg::CPU_W-1:0]     cpu;
  logic [flc_pkg::BIN_W-1:0]     bin;
  logic [flc_pkg::HANDLE_W-1:0]  obj_handle;
  logic [flc_pkg::SIZE_W-1:0]    obj_size;

  modport source (output valid, mode, cpu, bin, obj_handle, obj_size, input ready);
  modport sink   (input valid, mode, cpu, bin, obj_handle, obj_size, output ready);
endinterface

### rtl/flc_out_if.sv
`timescale 1ns / 1ps
// flc_out_if: result channel (valid/ready plus success and handle).
// Depends on flc_pkg.
interface flc_out_if;
  logic                          valid;
  logic                          ready;
  logic                          success;
  logic [flc_pkg::HANDLE_W-1:0]  got_handle;

  modport source (output valid, success, got_handle, input ready);
  modport sink   (input valid, success, got_handle, output ready);
endinterface

### rtl/flc_ctrl.sv
`timescale 1ns / 1ps
// flc_ctrl: sequencing state machine of the object cache.
// Depends on flc_pkg.
module flc_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  flc_pkg::sts_t   sts,
  output flc_pkg::cmd_t   cmd
);

  flc_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= flc_pkg::S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      flc_pkg::S_CLEAR: begin
        if (sts.clear_last) state_nxt = flc_pkg::S_IDLE;
      end
      flc_pkg::S_IDLE: begin
        if (in_valid) state_nxt = flc_pkg::S_LOOK;
      end
      flc_pkg::S_LOOK: begin
        if (sts.out_free) state_nxt = sts.need_pop ? flc_pkg::S_POP : flc_pkg::S_IDLE;
      end
      flc_pkg::S_POP: begin
        if (sts.out_free) state_nxt = flc_pkg::S_IDLE;
      end
      default: state_nxt = flc_pkg::S_CLEAR;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      flc_pkg::S_CLEAR: cmd.clear = 1'b1;
      flc_pkg::S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      flc_pkg::S_LOOK: cmd.look = sts.out_free;
      flc_pkg::S_POP:  cmd.pop  = sts.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

### rtl/flc_datapath.sv
`timescale 1ns / 1ps
// flc_datapath: list memories, global stacks, link memory and result register.
// Depends on flc_pkg; driven by flc_ctrl commands.
module flc_datapath #(
  parameter int NUM_CPUS     = 4,
  parameter int NUM_BINS     = 16,
  parameter int GLOBAL_DEPTH = 8,
  parameter int NUM_OBJECTS  = 4096
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  flc_pkg::cmd_t                 cmd,
  output flc_pkg::sts_t                 sts,
  input  logic                          in_mode,
  input  logic [flc_pkg::CPU_W-1:0]     in_cpu,
  input  logic [flc_pkg::BIN_W-1:0]     in_bin,
  input  logic [flc_pkg::HANDLE_W-1:0]  in_obj_handle,
  input  logic [flc_pkg::SIZE_W-1:0]    in_obj_size,
  input  logic [flc_pkg::BYTES_W-1:0]   byte_limit,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_success,
  output logic [flc_pkg::HANDLE_W-1:0]  out_got_handle
);

  localparam int L   = NUM_CPUS * NUM_BINS * 2;
  localparam int G   = NUM_BINS * GLOBAL_DEPTH;
  localparam int LAW = $clog2(L);
  localparam int GAW = (G > 1) ? $clog2(G) : 1;
  localparam int BW  = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
  localparam int CW  = $clog2(GLOBAL_DEPTH + 1);
  localparam int NAW = $clog2(NUM_OBJECTS);
  localparam int HW  = flc_pkg::HEAD_W;
  localparam int YW  = flc_pkg::BYTES_W;
  localparam int EW  = flc_pkg::ENTRY_W;
  localparam int KW  = flc_pkg::HANDLE_W;

  // storage
  logic [EW-1:0] lmem [L];
  logic [EW-1:0] gmem [G];
  logic [HW-1:0] nmem [NUM_OBJECTS];
  logic [CW-1:0] cnt_r [NUM_BINS];

  logic [EW-1:0] rd0_r, rd1_r, grd_r;
  logic [HW-1:0] nrd_r;

  // captured item
  logic                        mode_r, bin_ok_r, handle_ok_r;
  logic [BW-1:0]               bin_r;
  logic [LAW-1:0]              l0_r;
  logic [KW-1:0]               handle_r;
  logic [flc_pkg::SIZE_W-1:0]  size_r;

  // pop in flight
  logic [LAW-1:0] pop_idx_r,   pop_idx_nxt;
  logic [KW-1:0]  pop_hd_r,    pop_hd_nxt;
  logic [YW-1:0]  pop_bytes_r, pop_bytes_nxt;

  logic [LAW-1:0] clr_cnt_r;

  logic          out_valid_r;
  logic          out_success_r;
  logic [KW-1:0] out_got_r;

  function automatic logic [flc_pkg::CPU_W-1:0] cpu_mod(input logic [flc_pkg::CPU_W-1:0] c);
    logic [flc_pkg::CPU_W-1:0] v;
    v = c;
    for (int i = 0; i < 3; i++) begin
      if (int'(v) >= NUM_CPUS) v = v - flc_pkg::CPU_W'(NUM_CPUS);
    end
    return v;
  endfunction

  // capture-side address calculation
  logic          in_bin_ok;
  logic [BW-1:0] bin_sel;
  logic [LAW-1:0] l0_in;
  logic [GAW-1:0] g_rd_addr;

  always_comb begin
    in_bin_ok = int'(in_bin) < NUM_BINS;
    bin_sel   = in_bin_ok ? BW'(in_bin) : '0;
    l0_in     = LAW'((int'(cpu_mod(in_cpu)) * NUM_BINS + int'(bin_sel)) * 2);
    g_rd_addr = GAW'(int'(bin_sel) * GLOBAL_DEPTH + int'(cnt_r[bin_sel]) - 1);
  end

  // decision logic for the look cycle
  logic [HW-1:0] h0, h1, gh;
  logic [YW-1:0] b0, b1, gb;
  logic [CW-1:0] n;
  logic          need_pop, look_ok;
  logic          push_en;
  logic [LAW-1:0] push_idx;
  logic [HW-1:0] push_h;
  logic [YW-1:0] push_b;
  logic          lw_look_en;
  logic [LAW-1:0] lw_look_addr;
  logic [EW-1:0] lw_look_data;
  logic          spill, refill;
  logic [YW:0]   push_sum;
  logic [YW-1:0] push_new_b;

  always_comb begin
    h0 = rd0_r[EW-1:YW];  b0 = rd0_r[YW-1:0];
    h1 = rd1_r[EW-1:YW];  b1 = rd1_r[YW-1:0];
    gh = grd_r[EW-1:YW];  gb = grd_r[YW-1:0];
    n  = cnt_r[bin_r];
    need_pop      = 1'b0;
    look_ok       = 1'b0;
    push_en       = 1'b0;
    push_idx      = l0_r;
    push_h        = '0;
    push_b        = '0;
    spill         = 1'b0;
    refill        = 1'b0;
    pop_idx_nxt   = l0_r;
    pop_hd_nxt    = h0[KW-1:0];
    pop_bytes_nxt = b0;
    lw_look_en    = 1'b0;
    lw_look_addr  = l0_r;
    lw_look_data  = rd0_r;
    if (bin_ok_r) begin
      if (mode_r == flc_pkg::MODE_GET) begin
        if (h0[KW]) begin
          need_pop = 1'b1;
        end else if (h1[KW]) begin
          need_pop      = 1'b1;
          pop_idx_nxt   = l0_r | LAW'(1);
          pop_hd_nxt    = h1[KW-1:0];
          pop_bytes_nxt = b1;
        end else if (n != '0 && int'(n) <= GLOBAL_DEPTH) begin
          refill        = 1'b1;
          pop_hd_nxt    = gh[KW-1:0];
          pop_bytes_nxt = gb;
          if (gh[KW]) begin
            need_pop = 1'b1;
          end else begin
            // empty list pulled in: store it, get misses
            lw_look_en   = 1'b1;
            lw_look_data = grd_r;
          end
        end
      end else if (handle_ok_r) begin
        if (b0 < byte_limit) begin
          push_en = 1'b1; push_h = h0; push_b = b0;
        end else if (b1 < byte_limit) begin
          push_en = 1'b1; push_idx = l0_r | LAW'(1); push_h = h1; push_b = b1;
        end else if (int'(n) < GLOBAL_DEPTH) begin
          spill   = 1'b1;
          push_en = 1'b1;
        end
      end
    end
    push_sum   = {1'b0, push_b} + (YW+1)'(size_r);
    push_new_b = !push_h[KW] ? YW'(size_r) : (push_sum[YW] ? flc_pkg::BYTES_MAX : push_sum[YW-1:0]);
    if (push_en) begin
      look_ok      = 1'b1;
      lw_look_en   = 1'b1;
      lw_look_addr = push_idx;
      lw_look_data = {1'b1, handle_r, push_new_b};
    end
  end

  // pop completion
  logic [HW-1:0] pop_new_h;
  logic [YW-1:0] pop_new_b;

  always_comb begin
    pop_new_h = (int'(pop_hd_r) < NUM_OBJECTS) ? nrd_r : '0;
    pop_new_b = (pop_bytes_r >= YW'(size_r)) ? pop_bytes_r - YW'(size_r) : '0;
  end

  // local list memory: one write port, two read ports
  logic           lw_en;
  logic [LAW-1:0] lw_addr;
  logic [EW-1:0]  lw_data;

  always_comb begin
    lw_en   = 1'b0;
    lw_addr = clr_cnt_r;
    lw_data = '0;
    if (cmd.clear) begin
      lw_en = 1'b1;
    end else if (cmd.look) begin
      lw_en   = lw_look_en;
      lw_addr = lw_look_addr;
      lw_data = lw_look_data;
    end else if (cmd.pop) begin
      lw_en   = 1'b1;
      lw_addr = pop_idx_r;
      lw_data = {pop_new_h, pop_new_b};
    end
  end

  always_ff @(posedge clk) begin
    if (lw_en) lmem[lw_addr] <= lw_data;
    if (cmd.capture) begin
      rd0_r <= lmem[l0_in];
      rd1_r <= lmem[l0_in | LAW'(1)];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.look && spill) gmem[GAW'(int'(bin_r) * GLOBAL_DEPTH + int'(n))] <= rd0_r;
    if (cmd.capture) grd_r <= gmem[g_rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.look && push_en) nmem[NAW'(handle_r)] <= push_h;
    if (cmd.look) nrd_r <= nmem[NAW'(pop_hd_nxt)];
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r      <= in_mode;
      bin_ok_r    <= in_bin_ok;
      handle_ok_r <= int'(in_obj_handle) < NUM_OBJECTS;
      bin_r       <= bin_sel;
      l0_r        <= l0_in;
      handle_r    <= in_obj_handle;
      size_r      <= in_obj_size;
    end
    if (cmd.look) begin
      pop_idx_r   <= pop_idx_nxt;
      pop_hd_r    <= pop_hd_nxt;
      pop_bytes_r <= pop_bytes_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_BINS; i++) cnt_r[i] <= '0;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.look && refill) cnt_r[bin_r] <= n - CW'(1);
      if (cmd.look && spill)  cnt_r[bin_r] <= n + CW'(1);
      if (cmd.clear) clr_cnt_r <= clr_cnt_r + LAW'(1);
      if ((cmd.look && !need_pop) || cmd.pop) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.look && !need_pop) begin
      out_success_r <= look_ok;
      out_got_r     <= '0;
    end else if (cmd.pop) begin
      out_success_r <= 1'b1;
      out_got_r     <= pop_hd_r;
    end
  end

  assign sts.clear_last = clr_cnt_r == LAW'(L - 1);
  assign sts.need_pop   = need_pop;
  assign sts.out_free   = !out_valid_r || out_ready;

  assign out_valid      = out_valid_r;
  assign out_success    = out_success_r;
  assign out_got_handle = out_got_r;

endmodule

### rtl/free_list_object_cache.sv
`timescale 1ns / 1ps
// free_list_object_cache: top level, byte_limit register and APB port.
// Depends on flc_pkg, flc_in_if, flc_out_if, flc_ctrl, flc_datapath.
//
//  channel  | direction | transaction
//  ---------+-----------+---------------------------------------------------
//  in_if    | in        | get/put request: mode, cpu, bin, obj_handle, size
//  out_if   | out       | one result per request: success, got_handle
//  cfg_*    | in/out    | APB register access, byte_limit at address 0
//
// A put reads the list descriptors, then writes one in its look step. A get
// ends at its look step on a miss and adds a pop step on a hit: the popped
// head must be read back from the link memory before the list descriptor is
// rewritten. After reset a clearing pass writes every local list descriptor
// empty, with in_if.ready low. Global stacks and links are not cleared. A
// result waiting on out_if holds the item in flight at its look step and, on
// a get hit, again at its pop step; a new request is taken once that item is
// done.
module free_list_object_cache #(
  parameter int NUM_CPUS     = 4,
  parameter int NUM_BINS     = 16,
  parameter int GLOBAL_DEPTH = 8,
  parameter int NUM_OBJECTS  = 4096
) (
  input  logic                               clk,
  input  logic                               rst_n,
  flc_in_if.sink                             in_if,
  flc_out_if.source                          out_if,
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [flc_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [31:0]                        cfg_pwdata,
  output logic [31:0]                        cfg_prdata,
  output logic                               cfg_pready
);

  flc_pkg::cmd_t cmd;
  flc_pkg::sts_t sts;

  // byte_limit register
  logic [flc_pkg::BYTES_W-1:0] limit_r;
  logic                        cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite
                      && (cfg_paddr == flc_pkg::ADDR_BYTE_LIMIT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= flc_pkg::LIMIT_RESET;
    end else if (cfg_wr) begin
      limit_r <= cfg_pwdata[flc_pkg::BYTES_W-1:0];
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr == flc_pkg::ADDR_BYTE_LIMIT) cfg_prdata = 32'(limit_r);
  end

  flc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_if.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  flc_datapath #(
    .NUM_CPUS     (NUM_CPUS),
    .NUM_BINS     (NUM_BINS),
    .GLOBAL_DEPTH (GLOBAL_DEPTH),
    .NUM_OBJECTS  (NUM_OBJECTS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_mode        (in_if.mode),
    .in_cpu         (in_if.cpu),
    .in_bin         (in_if.bin),
    .in_obj_handle  (in_if.obj_handle),
    .in_obj_size    (in_if.obj_size),
    .byte_limit     (limit_r),
    .out_valid      (out_if.valid),
    .out_ready      (out_if.ready),
    .out_success    (out_if.success),
    .out_got_handle (out_if.got_handle)
  );

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// testbench: self-checking regression of free_list_object_cache.
// Depends on flc_pkg, flc_in_if, flc_out_if and the cache RTL.
module testbench;
  import flc_pkg::*;

  localparam int NCPU  = 4;
  localparam int NBIN  = 16;
  localparam int GDEP  = 8;
  localparam int NOBJ  = 4096;
  localparam int LIMIT = 20000;

  typedef struct packed {
    logic              mode;
    logic [CPU_W-1:0]  cpu;
    logic [BIN_W-1:0]  bin;
    logic [HANDLE_W-1:0] handle;
    logic [SIZE_W-1:0] size;
  } req_t;

  typedef struct packed {
    logic                success;
    logic [HANDLE_W-1:0] handle;
  } resp_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  flc_in_if  in_if ();
  flc_out_if out_if ();

  free_list_object_cache u_top (
    .clk, .rst_n, .in_if(in_if.sink), .out_if(out_if.source),
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata,
    .cfg_prdata, .cfg_pready
  );

  always #10 clk = ~clk;

  // Shadow of the cache contents.
  logic [BYTES_W-1:0]  lim_q;
  logic [HEAD_W-1:0]   heads [NCPU*NBIN*2];
  logic [BYTES_W-1:0]  bytes_q [NCPU*NBIN*2];
  logic [HEAD_W-1:0]   ghead [NBIN*GDEP];
  logic [BYTES_W-1:0]  gbytes [NBIN*GDEP];
  int unsigned         gcnt [NBIN];
  logic [HEAD_W-1:0]   links [NOBJ];

  req_t  pending_reqs [$];
  resp_t expected_resps [$];
  int    errors = 0;
  int    n_gets = 0, n_puts = 0;
  int    n_resp = 0;
  int    idle_cnt = 0;
  int    in_gap = 0, out_gap = 0;

  function automatic int gap_len();
    // mostly short gaps, occasionally a long one
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic list_pop(int idx, logic [SIZE_W-1:0] sz,
                                    output logic [HANDLE_W-1:0] h);
    logic [HEAD_W-1:0] hd;
    hd = heads[idx];
    if (!hd[HANDLE_W]) return 1'b0;
    h = hd[HANDLE_W-1:0];
    heads[idx] = links[h];
    bytes_q[idx] = (bytes_q[idx] >= sz) ? bytes_q[idx] - sz : '0;
    return 1'b1;
  endfunction

  function automatic void list_push(int idx, logic [HANDLE_W-1:0] h,
                                    logic [SIZE_W-1:0] sz);
    logic [BYTES_W:0] s;
    links[h] = heads[idx];
    if (!heads[idx][HANDLE_W]) begin
      bytes_q[idx] = BYTES_W'(sz);
    end else begin
      s = bytes_q[idx] + sz;
      bytes_q[idx] = (s > BYTES_MAX) ? BYTES_MAX : s[BYTES_W-1:0];
    end
    heads[idx] = {1'b1, h};
  endfunction

  // Predicts one response and advances the shadow state.
  function automatic resp_t cache_access(req_t r);
    resp_t o;
    int l0, l1, g, n;
    logic [HANDLE_W-1:0] got;
    o = '0;
    got = '0;
    l0 = ((r.cpu % NCPU) * NBIN + r.bin) * 2;
    l1 = l0 + 1;
    n = gcnt[r.bin];
    if (r.mode == MODE_GET) begin
      if (list_pop(l0, r.size, got) || list_pop(l1, r.size, got)) begin
        o.success = 1'b1;
      end else if (n > 0) begin
        g = r.bin * GDEP + n - 1;
        heads[l0] = ghead[g];
        bytes_q[l0] = gbytes[g];
        gcnt[r.bin] = n - 1;
        o.success = list_pop(l0, r.size, got);
      end
      if (o.success) o.handle = got;
    end else begin
      if (bytes_q[l0] < lim_q) begin
        list_push(l0, r.handle, r.size);
        o.success = 1'b1;
      end else if (bytes_q[l1] < lim_q) begin
        list_push(l1, r.handle, r.size);
        o.success = 1'b1;
      end else if (n < GDEP) begin
        // spill list 0 to the global stack, then push
        g = r.bin * GDEP + n;
        ghead[g] = heads[l0];
        gbytes[g] = bytes_q[l0];
        gcnt[r.bin] = n + 1;
        heads[l0] = '0;
        bytes_q[l0] = '0;
        list_push(l0, r.handle, r.size);
        o.success = 1'b1;
      end
    end
    return o;
  endfunction

  task automatic report(string what, int got_v, int exp_v);
    $display("mismatch %s: got %0h expected %0h", what, got_v, exp_v);
    errors++;
  endtask

  // Driver: next queued request when the channel is free.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || in_if.ready) begin
      if (in_if.valid) begin
        expected_resps.push_back(cache_access({in_if.mode, in_if.cpu, in_if.bin,
                                               in_if.obj_handle, in_if.obj_size}));
        in_gap = gap_len();
      end
      if (in_gap > 0 || pending_reqs.size() == 0) begin
        if (in_gap > 0) in_gap--;
        in_if.valid <= 1'b0;
      end else begin
        req_t r;
        r = pending_reqs.pop_front();
        in_if.valid <= 1'b1;
        in_if.mode <= r.mode;
        in_if.cpu <= r.cpu;
        in_if.bin <= r.bin;
        in_if.obj_handle <= r.handle;
        in_if.obj_size <= r.size;
      end
    end
  end

  // Monitor: compare each response with the oldest prediction.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        n_resp++;
        if (expected_resps.size() == 0) begin
          report("unexpected response", out_if.success, 0);
        end else begin
          resp_t e;
          e = expected_resps.pop_front();
          if (out_if.success !== e.success) report("success", out_if.success, e.success);
          if (out_if.got_handle !== e.handle) report("got_handle", out_if.got_handle, e.handle);
        end
        out_gap = gap_len();
      end
      if (out_gap > 0) begin
        out_gap--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles with no transaction on either channel.
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || !rst_n)
      idle_cnt <= 0;
    else
      idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= LIMIT) begin
      $display("timeout after %0d idle cycles", idle_cnt);
      $display("free_list_object_cache regression: fail");
      $finish;
    end
  end

  initial begin
    in_if.mode = 1'b0;
    in_if.cpu = '0;
    in_if.bin = '0;
    in_if.obj_handle = '0;
    in_if.obj_size = '0;
    in_if.valid = 1'b0;
    out_if.ready = 1'b0;
  end

  task automatic cfg_write(logic [BYTES_W-1:0] v);
    @(posedge clk);
    cfg_psel <= 1'b1; cfg_pwrite <= 1'b1; cfg_penable <= 1'b0;
    cfg_paddr <= ADDR_BYTE_LIMIT; cfg_pwdata <= 32'(v);
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    lim_q = v;
  endtask

  task automatic queue_req(logic m, int c, int b, int h, int s);
    req_t r;
    r.mode = m; r.cpu = c; r.bin = b; r.handle = h; r.size = s;
    if (m == MODE_GET) n_gets++; else n_puts++;
    pending_reqs.push_back(r);
  endtask

  // Wait for all predictions to drain, then let the block settle.
  task automatic drain();
    while (pending_reqs.size() != 0 || in_if.valid || expected_resps.size() != 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // Random phase: put/get mix on one hot cpu/bin pair plus noise.
  task automatic random_phase(int count);
    int c, b, hot_c, hot_b;
    hot_c = $urandom_range(0, 3);
    hot_b = $urandom_range(0, 15);
    for (int i = 0; i < count; i++) begin
      c = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : hot_c;
      b = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : hot_b;
      if ($urandom_range(0, 99) < 55)
        queue_req(MODE_PUT, c, b, $urandom_range(0, NOBJ - 1),
                  ($urandom_range(0, 9) == 0) ? $urandom_range(1, 32767)
                                              : $urandom_range(1, 16384));
      else
        queue_req(MODE_GET, c, b, $urandom_range(0, NOBJ - 1),
                  $urandom_range(1, 16384));
    end
    drain();
  endtask

  initial begin
    for (int i = 0; i < NCPU*NBIN*2; i++) begin
      heads[i] = '0;
      bytes_q[i] = '0;
    end
    for (int i = 0; i < NBIN*GDEP; i++) begin
      ghead[i] = '0;
      gbytes[i] = '0;
    end
    for (int i = 0; i < NBIN; i++) gcnt[i] = 0;
    for (int i = 0; i < NOBJ; i++) links[i] = '0;
    lim_q = LIMIT_RESET;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty get, field extremes, double put, saturation.
    queue_req(MODE_GET, 0, 0, 0, 1);
    queue_req(MODE_PUT, 3, 15, 4095, 16384);
    queue_req(MODE_PUT, 3, 15, 4095, 32767);
    queue_req(MODE_GET, 3, 15, 0, 32767);
    queue_req(MODE_GET, 3, 15, 0, 1);
    queue_req(MODE_GET, 3, 15, 0, 1);
    queue_req(MODE_PUT, 0, 0, 0, 1);
    queue_req(MODE_GET, 0, 0, 4095, 5);
    drain();

    // Tiny limit forces spills, full global stack refusals and refills.
    cfg_write(1);
    for (int i = 0; i < 12; i++) queue_req(MODE_PUT, 1, 7, 100 + i, 3);
    for (int i = 0; i < 13; i++) queue_req(MODE_GET, 1, 7, 0, 2);
    drain();
    random_phase(350);

    // Zero limit: every put spills, or is refused once the bin's global stack is full.
    cfg_write(0);
    random_phase(150);

    cfg_write(BYTES_MAX);
    random_phase(250);

    cfg_write(40000);
    random_phase(300);

    $display("covered %0d gets and %0d puts, %0d responses checked",
             n_gets, n_puts, n_resp);
    if (errors == 0)
      $display("free_list_object_cache regression: pass");
    else
      $display("free_list_object_cache regression: fail");
    $finish;
  end
endmodule

### files.f
rtl/flc_pkg.sv
rtl/flc_in_if.sv
rtl/flc_out_if.sv
rtl/flc_ctrl.sv
rtl/flc_datapath.sv
rtl/free_list_object_cache.sv
tb/testbench.sv
